FILE: rtl/core/mvob_pkg.sv
// Shared constants, types and constant tables of the oscillator bank.
package mvob_pkg;

    localparam int VOICE_COUNT     = 72;
    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 8;
    localparam int SAMPLE_RATE     = 11025;

    localparam int VIDX_W   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int SINE_N   = 1 << SINE_TABLE_BITS;
    localparam int SIDX_W   = SINE_TABLE_BITS + 1;
    localparam int SINE_W   = 17;                 // table entries 0..65536
    localparam int VAL_W    = SINE_W + 2;         // signed per-voice value
    localparam int SUM_W    = VAL_W + VIDX_W;     // signed mix accumulator
    localparam int AMP_W    = 16;                 // noise amplitude
    localparam int SEED_W   = 16;
    localparam int SAMPLE_W = 24;

    localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
    localparam logic [SEED_W-1:0] LFSR_MASK   = 16'hB400;
    localparam logic [SEED_W-1:0] SEED_RESET  = 16'h0001;

    typedef enum logic [1:0] {
        OP_SET     = 2'd0,
        OP_SILENCE = 2'd1,
        OP_TICK    = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        WV_SILENT   = 3'd0,
        WV_SINE     = 3'd1,
        WV_TRIANGLE = 3'd2,
        WV_SAWTOOTH = 3'd3,
        WV_SQUARE   = 3'd4,
        WV_NOISE    = 3'd5
    } t_wave;

    // controller -> datapath
    typedef struct packed {
        logic              start;     // tick accepted: clear mix
        logic              rd_en;     // read voice state at rd_addr
        logic [VIDX_W-1:0] rd_addr;
        logic              set_wave;  // set one voice waveform
        logic              clr_wave;  // silence all voices
        logic              load_out;  // move mix to output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_status;

    typedef logic [11:0][31:0]                  t_semi_rom;
    typedef logic [VOICE_COUNT-1:0][PHASE_BITS-1:0] t_step_rom;
    typedef logic [VOICE_COUNT-1:0][AMP_W-1:0]  t_amp_rom;
    typedef logic [SINE_N:0][SINE_W-1:0]        t_sine_rom;

    // Q24 semitone ratios, entry 11 leftmost
    localparam t_semi_rom SEMITONE_Q24 = {
        32'd31671166, 32'd29893600, 32'd28215802, 32'd26632170,
        32'd25137421, 32'd23726566, 32'd22394897, 32'd21137968,
        32'd19951585, 32'd18831788, 32'd17774841, 32'd16777216
    };

    // twice the lowest-octave noise amplitude, 50 * 2^41 / f, rounded down;
    // entry 11 leftmost
    localparam logic [11:0][63:0] NOISE_AMP2_BASE = {
        (64'd50 << 41) / (64'd110 * 64'd31671166),
        (64'd50 << 41) / (64'd110 * 64'd29893600),
        (64'd50 << 41) / (64'd110 * 64'd28215802),
        (64'd50 << 41) / (64'd110 * 64'd26632170),
        (64'd50 << 41) / (64'd110 * 64'd25137421),
        (64'd50 << 41) / (64'd110 * 64'd23726566),
        (64'd50 << 41) / (64'd110 * 64'd22394897),
        (64'd50 << 41) / (64'd110 * 64'd21137968),
        (64'd50 << 41) / (64'd110 * 64'd19951585),
        (64'd50 << 41) / (64'd110 * 64'd18831788),
        (64'd50 << 41) / (64'd110 * 64'd17774841),
        (64'd50 << 41) / (64'd110 * 64'd16777216)
    };

    function automatic logic [63:0] voice_freq_q24(int j);
        return (64'd110 * 64'(SEMITONE_Q24[j % 12])) << (j / 12);
    endfunction

    function automatic t_step_rom build_step_rom();
        t_step_rom   rom;
        logic [63:0] f;
        logic [63:0] q;
        logic [63:0] half;
        half = 64'd1 << (43 - PHASE_BITS);
        for (int j = 0; j < VOICE_COUNT; j++) begin
            f      = voice_freq_q24(j);
            q      = (f << 20) / 64'(SAMPLE_RATE);
            rom[j] = PHASE_BITS'((q + half) >> (44 - PHASE_BITS));
        end
        return rom;
    endfunction

    // Rounded amplitude: each octave up halves it, rounding on the last shift.
    function automatic t_amp_rom build_amp_rom();
        t_amp_rom rom;
        int       oct;
        for (int j = 0; j < VOICE_COUNT; j++) begin
            oct    = j / 12;
            rom[j] = AMP_W'((NOISE_AMP2_BASE[j % 12] + (64'd1 << oct)) >> (oct + 1));
        end
        return rom;
    endfunction

    // Quarter-wave sine, Q30 Taylor series with truncating products.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        longint      s;
        longint      e;
        for (int i = 0; i <= SINE_N; i++) begin
            a    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
            a2   = (a * a) >> 30;
            term = a;
            s    = longint'(a);
            for (int k = 1; k <= 6; k++) begin
                term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if ((k & 1) != 0) s -= longint'(term);
                else              s += longint'(term);
            end
            if (s < 0) s = 0;
            e = (s + 64'sd8192) >>> 14;
            if (e > 65536) e = 65536;
            rom[i] = SINE_W'(e);
        end
        return rom;
    endfunction

    localparam t_step_rom STEP_ROM  = build_step_rom();
    localparam t_amp_rom  NOISE_AMP = build_amp_rom();
    localparam t_sine_rom SINE_ROM  = build_sine_rom();

endpackage

FILE: rtl/core/mvob_ctrl.sv
// Sequencer: input handshake, voice walk and output hand-off.
module mvob_ctrl import mvob_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  t_status     i_status,
    output t_cmd        o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [VIDX_W-1:0] r_cnt, n_cnt;
    logic              r_drain, n_drain;
    logic              in_acc;
    logic              is_set, is_silence, is_tick;

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        is_set     = 1'b0;
        is_silence = 1'b0;
        is_tick    = 1'b0;
        unique case (t_op'(i_operation))
            OP_SET:     is_set     = 1'b1;
            OP_SILENCE: is_silence = 1'b1;
            OP_TICK:    is_tick    = 1'b1;
            default:    ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_drain = r_drain;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && is_tick) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                end
            end
            S_RUN: begin
                if (r_cnt == VIDX_W'(VOICE_COUNT - 1)) begin
                    n_state = S_DRAIN;
                    n_drain = 1'b0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                // drains the value stage, then the accumulate stage
                n_drain = 1'b1;
                if (r_drain) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = in_acc && is_tick;
        o_cmd.set_wave = in_acc && is_set;
        o_cmd.clr_wave = in_acc && is_silence;
        o_cmd.rd_en    = (r_state == S_RUN);
        o_cmd.rd_addr  = r_cnt;
        o_cmd.load_out = (r_state == S_DONE) && i_status.out_free;
    end

endmodule

FILE: rtl/core/mvob_datapath.sv
// Voice memories, waveform evaluation, noise LFSR, mix and output register.
module mvob_datapath import mvob_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    input  logic [6:0]                 i_voice_index,
    input  logic [2:0]                 i_waveform,
    input  logic                       i_cfg_we,
    input  logic [SEED_W-1:0]          i_cfg_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    localparam logic signed [VAL_W-1:0] TRI_PEAK = VAL_W'(131072);
    localparam logic signed [VAL_W-1:0] TRI_HALF = VAL_W'(65536);
    localparam logic signed [VAL_W-1:0] QUARTER  = VAL_W'(16384);

    // voice memories
    logic [2:0]            mem_wave  [VOICE_COUNT];
    logic [PHASE_BITS-1:0] mem_phase [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] r_wvld;
    logic [VOICE_COUNT-1:0] r_pvld;

    // read stage
    logic                  r_s1_vld;
    logic [VIDX_W-1:0]     r_s1_idx;
    logic [2:0]            r_rd_wave;
    logic [PHASE_BITS-1:0] r_rd_phase;
    logic                  r_s1_wvld;
    logic                  r_s1_pvld;

    // value stage
    logic                    r_s2_vld;
    logic signed [VAL_W-1:0] r_s2_val;

    logic signed [SUM_W-1:0]    r_acc;
    logic [SEED_W-1:0]          r_noise;
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out;

    logic                    set_ok;
    logic [PHASE_BITS-1:0]   phase_eff;
    logic [31:0]             u;
    logic [SINE_TABLE_BITS-1:0] sk;
    logic [SIDX_W-1:0]       sidx;
    logic signed [VAL_W-1:0] sine_v, tri_y, tri_a, tri_v, saw_v, sq_v, noise_v, val;
    logic                    noise_step;
    logic [SEED_W-1:0]       n_noise;

    assign set_ok = ({1'b0, i_voice_index} < 8'(VOICE_COUNT));

    // memory write / read
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_wave && set_ok)
            mem_wave[i_voice_index[VIDX_W-1:0]] <= i_waveform;
        if (r_s1_vld)
            mem_phase[r_s1_idx] <= phase_eff + STEP_ROM[r_s1_idx];
        if (i_cmd.rd_en) begin
            r_rd_wave  <= mem_wave[i_cmd.rd_addr];
            r_rd_phase <= mem_phase[i_cmd.rd_addr];
            r_s1_wvld  <= r_wvld[i_cmd.rd_addr];
            r_s1_pvld  <= r_pvld[i_cmd.rd_addr];
            r_s1_idx   <= i_cmd.rd_addr;
        end
    end

    // valid bits stand in for the reset value of both memories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld <= '0;
            r_pvld <= '0;
        end else begin
            if (i_cmd.clr_wave)
                r_wvld <= '0;
            else if (i_cmd.set_wave && set_ok)
                r_wvld[i_voice_index[VIDX_W-1:0]] <= 1'b1;
            if (r_s1_vld)
                r_pvld[r_s1_idx] <= 1'b1;
        end
    end

    // waveform evaluation on the read phase
    always_comb begin
        phase_eff = r_s1_pvld ? r_rd_phase : '0;
        u         = 32'(phase_eff) << (32 - PHASE_BITS);

        sk     = u[29 -: SINE_TABLE_BITS];
        sidx   = u[30] ? (SIDX_W'(SINE_N) - {1'b0, sk}) : {1'b0, sk};
        sine_v = $signed({1'b0, SINE_ROM[sidx], 1'b0});
        if (u[31]) sine_v = -sine_v;

        tri_y = TRI_PEAK - $signed({1'b0, u[31:14]});
        tri_a = tri_y[VAL_W-1] ? -tri_y : tri_y;
        tri_v = tri_a - TRI_HALF;

        saw_v = $signed({4'b0, u[31:17]}) - QUARTER;
        sq_v  = u[31] ? -QUARTER : QUARTER;

        noise_v = r_noise[0] ? $signed(VAL_W'(NOISE_AMP[r_s1_idx])) : '0;

        noise_step = 1'b0;
        val        = '0;
        case (t_wave'(r_s1_wvld ? r_rd_wave : WV_SILENT))
            WV_SINE:     val = sine_v;
            WV_TRIANGLE: val = tri_v;
            WV_SAWTOOTH: val = saw_v;
            WV_SQUARE:   val = sq_v;
            WV_NOISE: begin
                val        = noise_v;
                noise_step = r_s1_vld;
            end
            default:     val = '0;
        endcase

        n_noise = (r_noise >> 1) ^ (r_noise[0] ? LFSR_MASK : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_noise   <= SEED_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.rd_en;
            r_s2_vld <= r_s1_vld;
            if (i_cfg_we)
                r_noise <= i_cfg_data;
            else if (noise_step)
                r_noise <= n_noise;
            if (i_cmd.load_out)
                r_out_vld <= 1'b1;
            else if (i_ready)
                r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_val <= val;
        if (i_cmd.start)
            r_acc <= '0;
        else if (r_s2_vld)
            r_acc <= r_acc + {{(SUM_W-VAL_W){r_s2_val[VAL_W-1]}}, r_s2_val};
        // floor divide by 8; range of the sum keeps it inside 24 bits
        if (i_cmd.load_out)
            r_out <= {{(SAMPLE_W-SUM_W+3){r_acc[SUM_W-1]}}, r_acc[SUM_W-1:3]};
    end

    assign o_status.out_free = !r_out_vld || i_ready;
    assign o_valid           = r_out_vld;
    assign o_sample          = r_out;

endmodule

FILE: rtl/core/multi_voice_oscillator_bank.sv
// Top level of the multi-voice oscillator bank.
//
//  channel   direction  handshake                     word
//  --------  ---------  ----------------------------  --------------------------------
//  input     in         i_valid / o_ready             i_operation, i_voice_index,
//                                                     i_waveform
//  output    out        o_valid / i_ready             o_sample (signed Q8.16)
//  config    in         i_cfg_valid / o_cfg_ready     i_cfg_data (noise seed)
//
//  A set or silence word leaves the input open. During a tick the voice walk
//  reads one voice per cycle from the phase and waveform memories, with a
//  read stage, a value stage and an accumulate stage behind it.
//  A finished sample sits in the output register; new words are accepted
//  while it waits. A tick that finishes while the previous sample is still
//  untaken holds in its last state until the output register frees.
//  Reset (synchronous, active low) silences all voices, zeroes all phases
//  through valid bits and loads the noise register with 1. A config write
//  loads the noise register directly; o_cfg_ready is always high.
module multi_voice_oscillator_bank import mvob_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_operation,
    input  logic [6:0]                 i_voice_index,
    input  logic [2:0]                 i_waveform,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_sample,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [SEED_W-1:0]          i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // config must arrive only while idle (the block does not enforce it); it is always taken
    assign o_cfg_ready = 1'b1;

    mvob_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mvob_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_voice_index (i_voice_index),
        .i_waveform    (i_waveform),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_sample      (o_sample)
    );

endmodule

FILE: rtl/core/mvob_checker.sv
// Port-level assertions for the oscillator bank and their bind.
module mvob_checker import mvob_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic [1:0]                 i_operation,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic signed [SAMPLE_W-1:0] o_sample
);

    // stalled sample holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample))
        else $error("sample dropped or changed under stall");

    // a tick closes the input at the start of the voice walk
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_operation == OP_TICK |=> !o_ready ##1 !o_ready)
        else $error("input reopened during voice walk");

    // only a tick closes the input
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(i_valid && i_operation == OP_TICK))
        else $error("input closed without a tick");

    // set and silence words produce no sample
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_operation != OP_TICK |=> !$rose(o_valid))
        else $error("sample produced by a non-tick word");

endmodule

bind multi_voice_oscillator_bank mvob_checker u_mvob_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for the multi-voice oscillator bank: mixes predicted per tick.
`timescale 1ns / 1ps

module tb;
    import mvob_pkg::*;

    // Local copies of the bank geometry, used by the predictor.
    localparam int NUM_VOICES   = 72;
    localparam int SINE_SIZE    = 256;          // quarter-wave table steps
    localparam int DRAIN_CYCLES = 100;          // longer than one full tick walk
    localparam longint RUN_LIMIT_NS = 20_000_000;

    // Unused input codes, still driven to reach every bit pattern.
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [2:0] WV_UNUSED_LO = 3'd6;
    localparam logic [2:0] WV_UNUSED_HI = 3'd7;

    localparam logic [63:0]       QUARTER_TURN_Q30 = 64'd1686629713;
    localparam logic [15:0]       NOISE_TAPS       = 16'hB400;
    localparam logic [11:0][31:0] SEMI_Q24 = {
        32'd31671166, 32'd29893600, 32'd28215802, 32'd26632170,
        32'd25137421, 32'd23726566, 32'd22394897, 32'd21137968,
        32'd19951585, 32'd18831788, 32'd17774841, 32'd16777216
    };

    // DUT connections; every input is known from time zero.
    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_valid       = 1'b0;
    logic                       o_ready;
    logic [1:0]                 i_operation   = '0;
    logic [6:0]                 i_voice_index = '0;
    logic [2:0]                 i_waveform    = '0;
    logic                       o_valid;
    logic                       i_ready       = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic                       i_cfg_valid   = 1'b0;
    logic                       o_cfg_ready;
    logic [SEED_W-1:0]          i_cfg_data    = '0;

    // Predictor state: waveform and phase per voice, plus the noise register.
    logic [2:0]  wave_tab  [NUM_VOICES];
    logic [31:0] phase_tab [NUM_VOICES];
    logic [15:0] lfsr = 16'h0001;

    // Constant tables, built at time zero.
    logic [31:0] step_tab [NUM_VOICES];
    int          amp_tab  [NUM_VOICES];
    int          sine_tab [SINE_SIZE + 1];

    logic [SAMPLE_W-1:0] pending_samples [$];

    int src_idle_pct  = 20;
    int sink_idle_pct = 69;
    int hold_req      = 0;     // long receiver hold-off, picked up by the sink
    int hold_left     = 0;

    int words_sent      = 0;
    int samples_checked = 0;
    int seed_writes     = 0;
    int mismatches      = 0;

    multi_voice_oscillator_bank dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_voice_index (i_voice_index),
        .i_waveform    (i_waveform),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_sample      (o_sample),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Build the phase steps, noise amplitudes and quarter-wave sine from scratch.
    initial begin : voice_tables
        longint unsigned f;
        longint unsigned q;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint          s;
        int              j;
        int              i;
        int              k;
        for (j = 0; j < NUM_VOICES; j++) begin
            // 110 Hz times the semitone ratio, one octave up per twelve voices (Q24)
            f = (64'd110 * SEMI_Q24[j % 12]) << (j / 12);
            q = (f << 20) / 11025;                   // phase step in Q44
            step_tab[j] = 32'((q + 64'd2048) >> 12); // round to 32 phase bits
            amp_tab[j]  = int'(((64'd50 << 40) + (f >> 1)) / f);
            wave_tab[j]  = WV_SILENT;
            phase_tab[j] = '0;
        end
        for (i = 0; i <= SINE_SIZE; i++) begin
            a    = (QUARTER_TURN_Q30 * i) >> 8;
            a2   = (a * a) >> 30;
            term = a;
            s    = a;
            // Taylor series, each term truncated
            for (k = 1; k <= 6; k++) begin
                term = ((term * a2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1) s = s - $signed(term);
                else            s = s + $signed(term);
            end
            if (s < 0) s = 0;
            s = (s + 8192) >>> 14;
            if (s > 65536) s = 65536;
            sine_tab[i] = int'(s);
        end
    end

    // Value of one voice at its current phase; noise voices step the LFSR.
    function automatic int voice_level(int j);
        logic [31:0] u;
        int          v;
        logic        b;
        u = phase_tab[j];
        case (wave_tab[j])
            WV_SINE: begin
                // top two bits pick the quadrant, next eight the table step
                v = u[30] ? sine_tab[SINE_SIZE - u[29:22]] : sine_tab[u[29:22]];
                return u[31] ? -2 * v : 2 * v;
            end
            WV_TRIANGLE: begin
                v = 131072 - $signed({1'b0, u[31:14]});
                return (v < 0 ? -v : v) - 65536;
            end
            WV_SAWTOOTH: return $signed({1'b0, u[31:17]}) - 16384;
            WV_SQUARE:   return u[31] ? -16384 : 16384;
            WV_NOISE: begin
                b    = lfsr[0];
                lfsr = lfsr >> 1;
                if (b) lfsr = lfsr ^ NOISE_TAPS;
                return b ? amp_tab[j] : 0;
            end
            default: return 0;           // silent, and the two spare codes
        endcase
    endfunction

    // One tick: sum all voices in order, advance every phase, floor-divide by 8, clamp to 24 bits.
    function automatic logic [SAMPLE_W-1:0] mix_tick();
        longint acc;
        int     j;
        acc = 0;
        for (j = 0; j < NUM_VOICES; j++) acc += voice_level(j);
        for (j = 0; j < NUM_VOICES; j++) phase_tab[j] = phase_tab[j] + step_tab[j];
        acc = acc >>> 3;
        if (acc > 64'sd8388607)  acc = 64'sd8388607;
        if (acc < -64'sd8388608) acc = -64'sd8388608;
        return acc[SAMPLE_W-1:0];
    endfunction

    // Predictor update for one accepted word.
    function automatic void apply_word(logic [1:0] op, logic [6:0] vidx, logic [2:0] wf);
        int j;
        case (op)
            OP_SET:     if (vidx < NUM_VOICES) wave_tab[vidx] = wf;
            OP_SILENCE: for (j = 0; j < NUM_VOICES; j++) wave_tab[j] = WV_SILENT;
            OP_TICK:    pending_samples.push_back(mix_tick());
            default:    ;                    // spare operation: no effect
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 30)
            $display("[%0t] sample %0d: %s", $time, samples_checked, what);
    endtask

    // Offer one word, with random idle cycles ahead of it, and wait until taken.
    // Valid stays high after acceptance so back-to-back words need no re-raise.
    task automatic send_word(input logic [1:0] op, input logic [6:0] vidx,
                             input logic [2:0] wf);
        logic taken;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_voice_index <= vidx;
        i_waveform    <= wf;
        do begin
            @(negedge i_clk);
            taken = (o_ready === 1'b1);
            @(posedge i_clk);
        end while (!taken);
        apply_word(op, vidx, wf);
        words_sent++;
    endtask

    // Seed write, only once the bank has gone quiet.
    task automatic write_seed(input logic [15:0] seed);
        logic taken;
        i_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= seed;
        do begin
            @(negedge i_clk);
            taken = (o_cfg_ready === 1'b1);
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        lfsr = seed;                         // a write reloads the register at once
        seed_writes++;
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_req != 0) begin
            hold_left = hold_req - 1;
            hold_req  = 0;
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Output check: sampled mid-cycle, so the word is taken at the next edge.
    always @(negedge i_clk) begin : sample_check
        logic [SAMPLE_W-1:0] want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %0d", o_sample));
            end else begin
                want = pending_samples.pop_front();
                if (o_sample !== want)
                    report_mismatch($sformatf("got %0d, want %0d",
                                              o_sample, $signed(want)));
            end
            samples_checked++;
        end
    end

    // Reset state: every waveform, range extreme and corner code once.
    task automatic test_directed_words();
        send_word(OP_TICK, 7'd0, WV_SILENT);          // all silent, phases zero
        send_word(OP_SET, 7'd0, WV_SINE);
        send_word(OP_SET, 7'd35, WV_TRIANGLE);
        send_word(OP_SET, 7'd12, WV_SAWTOOTH);
        send_word(OP_SET, 7'd60, WV_SQUARE);
        send_word(OP_SET, 7'd71, WV_NOISE);
        send_word(OP_SET, 7'd70, WV_NOISE);
        send_word(OP_TICK, 7'd127, WV_UNUSED_HI);
        send_word(OP_TICK, 7'd0, WV_SILENT);
        // voice numbers past the bank are dropped
        send_word(OP_SET, 7'd72, WV_SINE);
        send_word(OP_SET, 7'd127, WV_UNUSED_HI);
        // spare waveform codes are kept but silent
        send_word(OP_SET, 7'd5, WV_UNUSED_LO);
        send_word(OP_SET, 7'd6, WV_UNUSED_HI);
        send_word(OP_UNUSED, 7'd3, WV_SINE);          // spare operation, no sample
        send_word(OP_TICK, 7'd0, WV_SILENT);
        send_word(OP_SILENCE, 7'd0, WV_SILENT);
        send_word(OP_TICK, 7'd0, WV_SILENT);
        send_word(OP_SET, 7'd1, WV_NOISE);
        send_word(OP_SET, 7'd71, WV_SINE);
        send_word(OP_TICK, 7'd0, WV_SILENT);
        send_word(OP_TICK, 7'd0, WV_SILENT);
    endtask

    // Seed extremes: all ones, then all zero, where noise voices stay quiet.
    task automatic test_seed_extremes();
        write_seed(16'hFFFF);
        send_word(OP_SET, 7'd10, WV_NOISE);
        send_word(OP_SET, 7'd20, WV_NOISE);
        send_word(OP_SET, 7'd30, WV_NOISE);
        send_word(OP_SET, 7'd71, WV_NOISE);
        repeat (3) send_word(OP_TICK, 7'd0, WV_SILENT);
        write_seed(16'h0000);
        repeat (3) send_word(OP_TICK, 7'd0, WV_SILENT);
        write_seed(16'h0001);
    endtask

    // Long receiver hold-off while ticks keep coming, so the input stalls.
    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_word(OP_SET, 7'd7, WV_SQUARE);
        send_word(OP_SET, 7'd40, WV_SINE);
        send_word(OP_SET, 7'd50, WV_NOISE);
        hold_req = 400;
        repeat (6) send_word(OP_TICK, 7'd0, WV_SILENT);
    endtask

    // Random traffic at one idle setting, with a fresh random seed.
    // Only words that change state or produce a sample are counted.
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_words);
        int          counted;
        int          r;
        logic [15:0] seed;
        logic [6:0]  vidx;
        logic [2:0]  wf;
        seed = 16'($urandom_range(65535, 1));
        write_seed(seed);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        counted = 0;
        while (counted < n_words) begin
            r    = $urandom_range(99);
            vidx = 7'($urandom_range(127));
            wf   = 3'($urandom_range(7));
            if (r < 50) begin
                send_word(OP_TICK, vidx, wf);
                counted++;
            end else if (r < 90) begin
                // mostly real voices and real waveforms
                if ($urandom_range(9) != 0) vidx = 7'($urandom_range(NUM_VOICES - 1));
                if ($urandom_range(9) != 0) wf = 3'($urandom_range(WV_NOISE));
                send_word(OP_SET, vidx, wf);
                if (vidx < NUM_VOICES) counted++;
            end else if (r < 95) begin
                send_word(OP_SILENCE, vidx, wf);
                counted++;
            end else begin
                send_word(OP_UNUSED, vidx, wf);
            end
        end
    endtask

    initial begin : main_sequence
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_words();
        test_seed_extremes();
        test_output_backpressure();
        test_random_traffic(20, 69, 560);
        test_random_traffic(69, 20, 560);
        test_random_traffic(0, 0, 560);

        i_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d input words, %0d samples checked, %0d seed writes",
                 words_sent, samples_checked, seed_writes);
        $display("  all waveforms, spare codes, seeds 0/1/all-ones, long output stall");
        if (mismatches == 0) begin
            $display("multi_voice_oscillator_bank: match");
        end else begin
            $display("multi_voice_oscillator_bank: mismatch");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #RUN_LIMIT_NS;
        $display("multi_voice_oscillator_bank: mismatch");
        $finish;
    end

endmodule
